@@ hw/rtl/uflin_pkg.sv @@
// Shared types, constants and the arctangent table of the unicycle linearisation block.
`timescale 1ns / 1ps

package uflin_pkg;

	// Default field widths.
	localparam int DATA_BITS_DEF  = 16;
	localparam int ANGLE_BITS_DEF = 16;

	// Rotation pipeline: 30 steps on Q1.30 values, with headroom bits.
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_W     = 34;
	localparam int TRIG_W       = CORDIC_W - 16;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// Reciprocal radius register, unsigned Q4.12.
	localparam int CFG_W = 16;
	localparam logic [CFG_W-1:0] INV_RADIUS_RESET = 16'd4096;

	// Arctangent of 2^-i as a fraction of a turn, 2^32 counts per turn.
	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	// Pipeline control handed to each section.
	typedef struct packed {
		logic en;
		logic valid;
	} pipe_ctl_t;

endpackage

@@ hw/rtl/uflin_cordic.sv @@
// Pipelined rotation unit giving cosine and sine of a binary angle in Q2.14.
`timescale 1ns / 1ps

module uflin_cordic #(
	parameter int ANGLE_BITS = uflin_pkg::ANGLE_BITS_DEF,
	parameter int TAG_W      = 2 * uflin_pkg::DATA_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  uflin_pkg::pipe_ctl_t                    ctl,
	input  logic [ANGLE_BITS-1:0]                   heading,
	input  logic [TAG_W-1:0]                        tag,
	output logic                                    out_valid,
	output logic signed [uflin_pkg::TRIG_W-1:0]     cos_o,
	output logic signed [uflin_pkg::TRIG_W-1:0]     sin_o,
	output logic [TAG_W-1:0]                        tag_o
);

	localparam int STEPS = uflin_pkg::CORDIC_STEPS;
	localparam int CW    = uflin_pkg::CORDIC_W;
	localparam int TW    = uflin_pkg::TRIG_W;

	// Stage 0 holds the folded start vector, stage k the result of step k-1.
	logic signed [CW-1:0] x_s [0:STEPS];
	logic signed [CW-1:0] y_s [0:STEPS];
	logic signed [CW-1:0] z_s [0:STEPS];
	logic                 flip_s [0:STEPS];
	logic [TAG_W-1:0]     tag_s [0:STEPS];
	logic [STEPS+1:0]     valid_s;

	logic [31:0] angle;
	logic        flip;
	logic [31:0] angle_f;
	logic signed [CW-1:0] x_rnd;
	logic signed [CW-1:0] y_rnd;

	// Widen to a 32-bit angle and fold the back half-plane onto the front one.
	always_comb begin
		angle   = {heading, {(32-ANGLE_BITS){1'b0}}};
		flip    = angle[31] ^ angle[30];
		angle_f = {angle[31] ^ flip, angle[30:0]};
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			x_s[0]    <= uflin_pkg::CORDIC_GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= {{(CW-32){angle_f[31]}}, angle_f};
			flip_s[0] <= flip;
			tag_s[0]  <= tag;
		end
	end

	// One rotation step per stage; the shift amount is fixed in each stage.
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic signed [CW-1:0] atan_k;
		assign atan_k = $signed(CW'(uflin_pkg::ATAN_TURN[k]));

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				if (z_s[k][CW-1]) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + atan_k;
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - atan_k;
				end
				flip_s[k+1] <= flip_s[k];
				tag_s[k+1]  <= tag_s[k];
			end
		end
	end

	// Round Q1.30 to Q2.14 and undo the fold.
	always_comb begin
		x_rnd = x_s[STEPS] + CW'(32768);
		y_rnd = y_s[STEPS] + CW'(32768);
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			cos_o <= flip_s[STEPS] ? -x_rnd[CW-1:16] : x_rnd[CW-1:16];
			sin_o <= flip_s[STEPS] ? -y_rnd[CW-1:16] : y_rnd[CW-1:16];
			tag_o <= tag_s[STEPS];
		end
	end

	// Valid bits travel beside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (ctl.en) begin
			valid_s <= {valid_s[STEPS:0], ctl.valid};
		end
	end

	assign out_valid = valid_s[STEPS+1];

	// TW is the width of the rounded part-select above.
	if (TW != CW - 16) begin : g_width_check
		$error("TRIG_W must equal CORDIC_W - 16");
	end

endmodule

@@ hw/rtl/uflin_mix.sv @@
// Products, scaling by the reciprocal radius and saturation of both commands.
`timescale 1ns / 1ps

module uflin_mix #(
	parameter int DATA_BITS = uflin_pkg::DATA_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  uflin_pkg::pipe_ctl_t                ctl,
	input  logic signed [uflin_pkg::TRIG_W-1:0] cos_i,
	input  logic signed [uflin_pkg::TRIG_W-1:0] sin_i,
	input  logic signed [DATA_BITS-1:0]         vel_x,
	input  logic signed [DATA_BITS-1:0]         vel_y,
	input  logic [uflin_pkg::CFG_W-1:0]         inv_radius,
	output logic                                out_valid,
	output logic signed [DATA_BITS-1:0]         linear_cmd,
	output logic signed [DATA_BITS-1:0]         angular_cmd,
	output logic                                saturated
);

	localparam int TW  = uflin_pkg::TRIG_W;
	localparam int PW  = TW + DATA_BITS;
	localparam int SW  = PW + 1;
	localparam int U1W = SW - 14;
	localparam int DW  = SW - 10;
	localparam int MW  = DW + uflin_pkg::CFG_W + 1;
	localparam int U2W = MW - 16;

	logic signed [PW-1:0]  cvx_s1, svy_s1, cvy_s1, svx_s1;
	logic signed [U1W-1:0] u1_s2, u1_s3;
	logic signed [DW-1:0]  d_s2;
	logic signed [MW-1:0]  prod_s3;
	logic [3:0]            valid_s;

	logic signed [SW-1:0]  sum_u1;
	logic signed [SW-1:0]  sum_d;
	logic signed [MW-1:0]  prod_rnd;
	logic signed [U2W-1:0] u2;
	logic                  ovf1, ovf2;
	logic signed [DATA_BITS-1:0] lin_c, ang_c;

	// Stage 1: the four trigonometric products.
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			cvx_s1 <= cos_i * vel_x;
			svy_s1 <= sin_i * vel_y;
			cvy_s1 <= cos_i * vel_y;
			svx_s1 <= sin_i * vel_x;
		end
	end

	// Stage 2: rounded sum for u1 (Q.8) and rounded difference for u2 (Q.12).
	always_comb begin
		sum_u1 = SW'(cvx_s1) + SW'(svy_s1) + SW'(8192);
		sum_d  = SW'(cvy_s1) - SW'(svx_s1) + SW'(512);
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			u1_s2 <= sum_u1[SW-1:14];
			d_s2  <= sum_d[SW-1:10];
		end
	end

	// Stage 3: scale the difference by the reciprocal radius.
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_s3 <= d_s2 * $signed({1'b0, inv_radius});
			u1_s3   <= u1_s2;
		end
	end

	// Stage 4: round u2 to Q.8 and clip both commands to the field range.
	always_comb begin
		prod_rnd = prod_s3 + MW'(32768);
		u2       = prod_rnd[MW-1:16];
		ovf1     = !((&u1_s3[U1W-1:DATA_BITS-1]) || !(|u1_s3[U1W-1:DATA_BITS-1]));
		ovf2     = !((&u2[U2W-1:DATA_BITS-1]) || !(|u2[U2W-1:DATA_BITS-1]));
		lin_c    = ovf1 ? {u1_s3[U1W-1], {(DATA_BITS-1){~u1_s3[U1W-1]}}}
		                : u1_s3[DATA_BITS-1:0];
		ang_c    = ovf2 ? {u2[U2W-1], {(DATA_BITS-1){~u2[U2W-1]}}}
		                : u2[DATA_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			linear_cmd  <= lin_c;
			angular_cmd <= ang_c;
			saturated   <= ovf1 | ovf2;
		end
	end

	// Valid bits for the four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (ctl.en) begin
			valid_s <= {valid_s[2:0], ctl.valid};
		end
	end

	assign out_valid = valid_s[3];

endmodule

@@ hw/rtl/unicycle_feedback_linearization_top.sv @@
// Top level of the unicycle feedback linearisation block: stream ports, register, pipeline.
`timescale 1ns / 1ps

// Turns a desired point velocity and a heading into wheel commands: linear = c*vx + s*vy and
// angular = (c*vy - s*vx) * inv_radius, with c and s from a 30-step rotation pipeline, both
// results in signed Q8.8 and clipped, tuser set when either was clipped. The block takes one
// transaction in every clock cycle unless the output stalls, and passes it through 36 register
// stages: 32 in the rotation pipeline (fold, 30 steps, rounding) and 4 in the multiply, scale
// and saturate stages. The whole pipeline moves on together; it holds only while a finished
// result waits at the output and the sink is not ready. inv_radius (unsigned Q4.12, reset 1.0)
// is read live, so write it only while no transaction is in flight; zero gives an angular
// command of 0.
module unicycle_feedback_linearization_top #(
	parameter int DATA_BITS  = uflin_pkg::DATA_BITS_DEF,
	parameter int ANGLE_BITS = uflin_pkg::ANGLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0: vel_x, vel_y, heading, zero padding.
	input  logic [((2*DATA_BITS+ANGLE_BITS+7)/8)*8-1:0] s_tdata,
	// Output stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Fields from bit 0: linear_cmd, angular_cmd, zero padding.
	output logic [((2*DATA_BITS+7)/8)*8-1:0] m_tdata,
	// Fields from bit 0: saturated.
	output logic                             m_tuser,
	// Reciprocal radius register.
	input  logic                             cfg_we,
	input  logic [uflin_pkg::CFG_W-1:0]      cfg_wdata
);

	localparam int OUT_TDATA_W = ((2*DATA_BITS+7)/8)*8;
	localparam int TAG_W       = 2 * DATA_BITS;
	localparam int TW          = uflin_pkg::TRIG_W;

	logic [uflin_pkg::CFG_W-1:0] inv_radius_q;
	logic                        adv;
	uflin_pkg::pipe_ctl_t        cordic_ctl;
	uflin_pkg::pipe_ctl_t        mix_ctl;
	logic                        cordic_valid;
	logic signed [TW-1:0]        cos_c, sin_c;
	logic [TAG_W-1:0]            tag_c;
	logic signed [DATA_BITS-1:0] linear_cmd, angular_cmd;
	logic                        saturated;

	// Reciprocal radius register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_radius_q <= uflin_pkg::INV_RADIUS_RESET;
		end else if (cfg_we) begin
			inv_radius_q <= cfg_wdata;
		end
	end

	// The pipeline advances whenever the output register is empty or being taken.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_comb begin
		cordic_ctl.en    = adv;
		cordic_ctl.valid = s_tvalid;
		mix_ctl.en       = adv;
		mix_ctl.valid    = cordic_valid;
	end

	uflin_cordic #(
		.ANGLE_BITS (ANGLE_BITS),
		.TAG_W      (TAG_W)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (cordic_ctl),
		.heading   (s_tdata[2*DATA_BITS +: ANGLE_BITS]),
		.tag       (s_tdata[TAG_W-1:0]),
		.out_valid (cordic_valid),
		.cos_o     (cos_c),
		.sin_o     (sin_c),
		.tag_o     (tag_c)
	);

	uflin_mix #(
		.DATA_BITS (DATA_BITS)
	) u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (mix_ctl),
		.cos_i       (cos_c),
		.sin_i       (sin_c),
		.vel_x       (tag_c[DATA_BITS-1:0]),
		.vel_y       (tag_c[TAG_W-1:DATA_BITS]),
		.inv_radius  (inv_radius_q),
		.out_valid   (m_tvalid),
		.linear_cmd  (linear_cmd),
		.angular_cmd (angular_cmd),
		.saturated   (saturated)
	);

	assign m_tdata = OUT_TDATA_W'({angular_cmd, linear_cmd});
	assign m_tuser = saturated;

	// A clipped result must sit at one end of the range in at least one command.
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && saturated |->
			linear_cmd  == {1'b0, {(DATA_BITS-1){1'b1}}} ||
			linear_cmd  == {1'b1, {(DATA_BITS-1){1'b0}}} ||
			angular_cmd == {1'b0, {(DATA_BITS-1){1'b1}}} ||
			angular_cmd == {1'b1, {(DATA_BITS-1){1'b0}}})
		else $error("saturated flag set without a clipped command");

	// While the input is held off, the rotation pipeline must not move.
	a_cordic_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(cordic_valid))
		else $error("rotation pipeline moved during a stall");

	// Back-pressure only ever comes from a result waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input held off without a waiting result");

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the unicycle feedback linearisation block.
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 250000;
	localparam int REPORT_MAX  = 10;
	localparam int DRAIN_WAIT  = 40;

	// Arctangent of 2^-i as a fraction of a turn, 2^32 counts per turn.
	localparam longint ATAN_STEP [30] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	// One wheel command as the block should return it.
	typedef struct {
		logic signed [15:0] linear;
		logic signed [15:0] angular;
		logic               clipped;
	} wheel_cmd_t;

	// Predicts wheel commands for accepted velocities and checks returned ones in order.
	class wheel_cmd_scoreboard;
		wheel_cmd_t  expected_cmds[$];
		logic [15:0] inv_radius;
		int          errors;

		function new();
			inv_radius = 16'd4096;
			errors = 0;
		endfunction

		function void set_inv_radius(logic [15:0] value);
			inv_radius = value;
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction

		// Cosine and sine of the heading in Q2.14, by a 30-step rotation on Q1.30 values.
		function void heading_trig(logic [15:0] heading, output longint cosv,
				output longint sinv);
			logic [31:0] angle;
			bit          flip;
			longint      x, y, z, nx;
			angle = {heading, 16'h0000};
			flip = 1'b0;
			// Fold the back half-plane onto the front one and flip the signs afterwards.
			if (angle >= 32'h40000000 && angle < 32'hC0000000) begin
				angle = angle - 32'h80000000;
				flip = 1'b1;
			end
			z = $signed(angle);
			x = 652032874;
			y = 0;
			for (int i = 0; i < 30; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z = z - ATAN_STEP[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z = z + ATAN_STEP[i];
				end
				x = nx;
			end
			x = (x + 32768) >>> 16;
			y = (y + 32768) >>> 16;
			cosv = flip ? -x : x;
			sinv = flip ? -y : y;
		endfunction

		function logic signed [15:0] clip16(longint value, inout logic hit);
			if (value > 32767) begin
				hit = 1'b1;
				return 16'sh7FFF;
			end
			if (value < -32768) begin
				hit = 1'b1;
				return 16'sh8000;
			end
			return value[15:0];
		endfunction

		// Works out the command for an accepted velocity and queues it.
		function void note_velocity(logic signed [15:0] vel_x, logic signed [15:0] vel_y,
				logic [15:0] heading);
			longint     cosv, sinv, vx, vy, lin, diff, ang;
			wheel_cmd_t cmd;
			vx = vel_x;
			vy = vel_y;
			heading_trig(heading, cosv, sinv);
			lin = (cosv * vx + sinv * vy + 8192) >>> 14;
			diff = (cosv * vy - sinv * vx + 512) >>> 10;
			ang = (diff * longint'(inv_radius) + 32768) >>> 16;
			cmd.clipped = 1'b0;
			cmd.linear = clip16(lin, cmd.clipped);
			cmd.angular = clip16(ang, cmd.clipped);
			expected_cmds.push_back(cmd);
		endfunction

		// Compares one returned command with the oldest queued one.
		function void check_command(logic signed [15:0] linear, logic signed [15:0] angular,
				logic clipped);
			wheel_cmd_t cmd;
			if (expected_cmds.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("Unexpected result: linear %0d angular %0d clipped %b",
						linear, angular, clipped);
				return;
			end
			cmd = expected_cmds.pop_front();
			if (linear !== cmd.linear || angular !== cmd.angular || clipped !== cmd.clipped)
				begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("Wrong result: expected %0d/%0d/%b, got %0d/%0d/%b",
						cmd.linear, cmd.angular, cmd.clipped, linear, angular, clipped);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	logic rx_hold = 1'b0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   cycle_count = 0;

	wheel_cmd_scoreboard board = new();

	unicycle_feedback_linearization_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Sink side: check each transaction and stall at random or while held off.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_command(m_tdata[15:0], m_tdata[31:16], m_tuser);
		if (rx_hold)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Offers one velocity transaction and notes it once it is taken.
	task automatic send_velocity(logic [15:0] vel_x, logic [15:0] vel_y, logic [15:0] heading);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {heading, vel_y, vel_x};
		do
			@(posedge clk);
		while (!s_tready);
		board.note_velocity(vel_x, vel_y, heading);
	endtask

	function automatic logic [15:0] random_velocity();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(511) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// One heading in four clusters round a quadrant edge; the fold changes at two of those edges.
	function automatic logic [15:0] random_heading();
		if ($urandom_range(3) == 0)
			return 16'($urandom_range(3) * 16384 + $urandom_range(4) - 2);
		return 16'($urandom);
	endfunction

	task automatic send_random_velocity();
		send_velocity(random_velocity(), random_velocity(), random_heading());
	endtask

	// Stops offering and waits until every queued command has come back.
	task automatic settle_pipeline();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_inv_radius(logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_inv_radius(value);
	endtask

	task automatic hold_receiver(int cycles);
		rx_hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold <= 1'b0;
	endtask

	// Stimulus.
	initial begin
		logic [15:0] setting;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset reciprocal: extremes, quadrant edges and clipping.
		tx_idle_pct = 26;
		rx_idle_pct = 75;
		send_velocity(16'h7FFF, 16'h0000, 16'h0000);
		send_velocity(16'h8000, 16'h0000, 16'h0000);
		send_velocity(16'h0000, 16'h7FFF, 16'h4000);
		send_velocity(16'h7FFF, 16'h7FFF, 16'h2000);
		send_velocity(16'h8000, 16'h8000, 16'h2000);
		send_velocity(16'h8000, 16'h7FFF, 16'h2000);
		send_velocity(16'd1000, -16'sd1000, 16'h8000);
		send_velocity(16'd256, 16'd512, 16'hC000);
		send_velocity(16'd300, -16'sd700, 16'h3FFF);
		send_velocity(16'd300, -16'sd700, 16'h4001);
		send_velocity(-16'sd900, 16'd100, 16'hBFFF);
		send_velocity(-16'sd900, 16'd100, 16'hC001);
		send_velocity(16'h7FFF, 16'h8000, 16'hFFFF);
		send_velocity(16'h0000, 16'h0000, 16'h5A5A);
		send_velocity(16'hFFFF, 16'h0001, 16'h1234);
		send_velocity(16'd256, 16'h0000, 16'h4000);
		settle_pipeline();

		// A zero reciprocal gives no turn rate at all.
		write_inv_radius(16'd0);
		send_velocity(16'h7FFF, 16'h8000, 16'h2000);
		send_velocity(16'd1200, -16'sd3000, 16'h6789);
		send_velocity(16'h8000, 16'h8000, 16'hE000);
		settle_pipeline();

		// The largest reciprocal clips the turn rate except for small velocities.
		write_inv_radius(16'hFFFF);
		send_velocity(16'd10, 16'd20, 16'h1000);
		send_velocity(16'h7FFF, 16'h0000, 16'h4000);
		send_velocity(16'h8000, 16'h0000, 16'h4000);
		send_velocity(-16'sd3, 16'd5, 16'h9000);
		settle_pipeline();

		// Random part: nine settings of the reciprocal over three idling modes.
		for (int seg = 0; seg < 9; seg++) begin
			case (seg)
				0: setting = 16'd1;
				1, 7: setting = 16'hFFFF;
				3: setting = 16'd0;
				5: setting = 16'd4096;
				6: setting = 16'($urandom_range(8192, 1));
				default: setting = 16'($urandom_range(65535, 1));
			endcase
			write_inv_radius(setting);
			case (seg / 3)
				0: begin
					tx_idle_pct = 26;
					rx_idle_pct = 75;
				end
				1: begin
					tx_idle_pct = 75;
					rx_idle_pct = 26;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			// With no idling, a long sink stall fills the pipeline and backs up the input.
			fork
				if (seg == 6)
					hold_receiver(300);
				repeat (95) send_random_velocity();
			join
			settle_pipeline();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/uflin_pkg.sv
hw/rtl/uflin_cordic.sv
hw/rtl/uflin_mix.sv
hw/rtl/unicycle_feedback_linearization_top.sv
bench/tb_top.sv
